// File: sv/nsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsm_pkg: shared types and constants
// Job and result widths, policy codes, job RAM entry layout and the
// controller/datapath command and status words.
// ----------------------------------------------------------------------------
package nsm_pkg;

  localparam int MAX_PROCS = 32;
  localparam int IDX_W     = $clog2(MAX_PROCS);
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);

  localparam int BURST_W   = 16;
  localparam int PRIO_W    = 8;
  localparam int ID_W      = 5;
  localparam int WAIT_W    = 21;
  localparam int ELAPSED_W = 22;
  localparam int TWAIT_W   = 25;
  localparam int TTAT_W    = 26;
  localparam int POLICY_W  = 2;

  localparam logic [POLICY_W-1:0] POLICY_FCFS = 2'd0;
  localparam logic [POLICY_W-1:0] POLICY_SJF  = 2'd1;
  localparam logic [POLICY_W-1:0] POLICY_PRIO = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] burst;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [ID_W-1:0]    job_id;
    logic [BURST_W-1:0] job_burst;
    logic [PRIO_W-1:0]  job_prio;
    logic [WAIT_W-1:0]  wait_time;
    logic [WAIT_W-1:0]  turnaround;
    logic [TWAIT_W-1:0] total_wait;
    logic [TTAT_W-1:0]  total_turnaround;
    logic               dropped_jobs;
    logic               final_slot;
  } result_t;

  typedef struct packed {
    logic accept;
    logic close;
    logic sort_rd;
    logic cur_load;
    logic scan;
    logic wb;
    logic emit_rd;
    logic emit_load;
    logic emit_hold;
  } cmd_t;

  typedef struct packed {
    logic count_nonzero;
    logic sortable;
    logic j_last;
    logic i_last;
    logic out_free;
    logic final_k;
  } status_t;

endpackage

// File: sv/nsm_job_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsm_job_if: job channel
// Valid/ready channel carrying one job word.
// ----------------------------------------------------------------------------
interface nsm_job_if import nsm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BURST_W-1:0] burst_time;
  logic [PRIO_W-1:0]  job_priority;
  logic               last_job;

  modport source (output valid, burst_time, job_priority, last_job, input ready);
  modport sink   (input valid, burst_time, job_priority, last_job, output ready);
endinterface

// File: sv/nsm_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsm_result_if: result channel
// Valid/ready channel carrying one schedule slot word.
// ----------------------------------------------------------------------------
interface nsm_result_if import nsm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ID_W-1:0]    job_id;
  logic [BURST_W-1:0] job_burst;
  logic [PRIO_W-1:0]  job_prio;
  logic [WAIT_W-1:0]  wait_time;
  logic [WAIT_W-1:0]  turnaround;
  logic [TWAIT_W-1:0] total_wait;
  logic [TTAT_W-1:0]  total_turnaround;
  logic               dropped_jobs;
  logic               final_slot;

  modport source (output valid, job_id, job_burst, job_prio, wait_time, turnaround,
                  total_wait, total_turnaround, dropped_jobs, final_slot,
                  input ready);
  modport sink   (input valid, job_id, job_burst, job_prio, wait_time, turnaround,
                  total_wait, total_turnaround, dropped_jobs, final_slot,
                  output ready);
endinterface

// File: sv/nonpreemptive_schedule_metrics.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nonpreemptive_schedule_metrics: batch job scheduler with wait metrics
// Loads a batch of jobs, orders them by arrival, burst or priority, and
// emits one schedule slot word per job with wait and turnaround totals.
// ----------------------------------------------------------------------------
// Load: one job word per cycle; jobs beyond capacity are dropped and flagged.
// Sort (burst/priority policies, n jobs): an initial read, then per position
// a load, a scan (one compare per cycle on the job RAM) and a write-back.
// Emission: a read state, then one slot word per cycle while results are taken.
// Reset (rst, synchronous): clears the controller, job count, overflow flag,
// policy and output valid; the job RAM is not cleared and needs no sweep.
module nonpreemptive_schedule_metrics import nsm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [POLICY_W-1:0] cfg_wr_data,
  nsm_job_if.sink             jobs,
  nsm_result_if.source        results
);

  cmd_t    cmd;
  status_t status;
  result_t out_word;

  nsm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (jobs.valid),
    .in_last  (jobs.last_job),
    .in_ready (jobs.ready),
    .status   (status),
    .cmd      (cmd)
  );

  nsm_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_burst    (jobs.burst_time),
    .in_prio     (jobs.job_priority),
    .cmd         (cmd),
    .status      (status),
    .out_ready   (results.ready),
    .out_valid   (results.valid),
    .out_word    (out_word)
  );

  assign results.job_id           = out_word.job_id;
  assign results.job_burst        = out_word.job_burst;
  assign results.job_prio         = out_word.job_prio;
  assign results.wait_time        = out_word.wait_time;
  assign results.turnaround       = out_word.turnaround;
  assign results.total_wait       = out_word.total_wait;
  assign results.total_turnaround = out_word.total_turnaround;
  assign results.dropped_jobs     = out_word.dropped_jobs;
  assign results.final_slot       = out_word.final_slot;

endmodule

// File: sv/nsm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsm_ram: generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module nsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/nsm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsm_ctrl: scheduler controller
// Sequences job loading, the exchange sort and result emission.
// ----------------------------------------------------------------------------
module nsm_ctrl import nsm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_last,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [6:0] {
    ST_LOAD     = 7'b0000001,
    ST_SORT_RD  = 7'b0000010,
    ST_SORT_CUR = 7'b0000100,
    ST_SCAN     = 7'b0001000,
    ST_WB       = 7'b0010000,
    ST_EMIT_RD  = 7'b0100000,
    ST_EMIT     = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state == ST_LOAD);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_LOAD: begin
        cmd.accept = accept;
        if (accept && in_last) begin
          cmd.close = 1'b1;
          if (status.sortable && status.count_nonzero) begin
            state_next = ST_SORT_RD;
          end else begin
            state_next = ST_EMIT_RD;
          end
        end
      end
      ST_SORT_RD: begin
        cmd.sort_rd = 1'b1;
        state_next  = ST_SORT_CUR;
      end
      ST_SORT_CUR: begin
        cmd.cur_load = 1'b1;
        state_next   = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.j_last) begin
          state_next = ST_WB;
        end
      end
      ST_WB: begin
        cmd.wb = 1'b1;
        if (status.i_last) begin
          state_next = ST_EMIT_RD;
        end else begin
          state_next = ST_SORT_CUR;
        end
      end
      ST_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        state_next  = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit_load = 1'b1;
          if (status.final_k) begin
            state_next = ST_LOAD;
          end
        end else begin
          cmd.emit_hold = 1'b1;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

endmodule

// File: sv/nsm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsm_datapath: scheduler datapath
// Job RAM, sort indices and compare, metric accumulators, output register.
// ----------------------------------------------------------------------------
module nsm_datapath import nsm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [POLICY_W-1:0] cfg_wr_data,
  input  logic [BURST_W-1:0]  in_burst,
  input  logic [PRIO_W-1:0]   in_prio,
  input  cmd_t                cmd,
  output status_t             status,
  input  logic                out_ready,
  output logic                out_valid,
  output result_t             out_word
);

  logic [POLICY_W-1:0]  policy;
  logic [CNT_W-1:0]     count;
  logic                 ovf;
  logic [IDX_W-1:0]     i;
  logic [IDX_W-1:0]     j;
  logic [IDX_W-1:0]     k;
  entry_t               cur;
  logic [ELAPSED_W-1:0] elapsed;
  logic [TWAIT_W-1:0]   wacc;
  logic [TTAT_W-1:0]    tacc;

  logic                 room;
  logic                 we;
  logic [IDX_W-1:0]     waddr;
  entry_t               wdata;
  logic [IDX_W-1:0]     raddr;
  logic [ENTRY_W-1:0]   rdata_raw;
  entry_t               rd;
  logic [BURST_W-1:0]   cur_key;
  logic [BURST_W-1:0]   rd_key;
  logic                 swap;
  logic [ELAPSED_W:0]   tat;
  logic [TWAIT_W-1:0]   wacc_next;
  logic [TTAT_W-1:0]    tacc_next;

  assign rd   = entry_t'(rdata_raw);
  assign room = (count != CNT_W'(MAX_PROCS));

  assign cur_key = (policy == POLICY_SJF) ? cur.burst : BURST_W'(cur.prio);
  assign rd_key  = (policy == POLICY_SJF) ? rd.burst  : BURST_W'(rd.prio);
  assign swap    = cmd.scan && (cur_key > rd_key);

  always_comb begin
    we    = 1'b0;
    waddr = i;
    wdata = cur;
    if (cmd.accept) begin
      we          = room;
      waddr       = IDX_W'(count);
      wdata.id    = ID_W'(count);
      wdata.prio  = in_prio;
      wdata.burst = in_burst;
    end else if (swap) begin
      we    = 1'b1;
      waddr = j;
    end else if (cmd.wb) begin
      we    = 1'b1;
      waddr = i;
    end
  end

  always_comb begin
    if (cmd.sort_rd) begin
      raddr = i;
    end else if (cmd.cur_load || cmd.wb) begin
      raddr = i + IDX_W'(1);
    end else if (cmd.scan) begin
      raddr = j + IDX_W'(1);
    end else if (cmd.emit_load) begin
      raddr = k + IDX_W'(1);
    end else if (cmd.emit_rd || cmd.emit_hold) begin
      raddr = k;
    end else begin
      raddr = '0;
    end
  end

  nsm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_PROCS)
  ) u_job_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_raw)
  );

  assign tat       = {1'b0, elapsed} + (ELAPSED_W + 1)'(rd.burst);
  assign wacc_next = wacc + TWAIT_W'(elapsed);
  assign tacc_next = tacc + TTAT_W'(tat);

  always_comb begin
    status.count_nonzero = (count != '0);
    status.sortable      = policy inside {POLICY_SJF, POLICY_PRIO};
    status.j_last        = (CNT_W'(j) + CNT_W'(1)) == count;
    status.i_last        = (CNT_W'(i) + CNT_W'(2)) == count;
    status.out_free      = !out_valid || out_ready;
    status.final_k       = (CNT_W'(k) + CNT_W'(1)) == count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      policy    <= POLICY_FCFS;
      count     <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        policy <= cfg_wr_data;
      end
      if (cmd.accept) begin
        if (room) begin
          count <= count + CNT_W'(1);
        end else begin
          ovf <= 1'b1;
        end
      end
      if (cmd.emit_load && status.final_k) begin
        count <= '0;
        ovf   <= 1'b0;
      end
      if (cmd.emit_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.close) begin
      i       <= '0;
      k       <= '0;
      elapsed <= '0;
      wacc    <= '0;
      tacc    <= '0;
    end
    if (cmd.cur_load) begin
      cur <= rd;
      j   <= i + IDX_W'(1);
    end
    if (cmd.scan) begin
      j <= j + IDX_W'(1);
      if (swap) begin
        cur <= rd;
      end
    end
    if (cmd.wb) begin
      i <= i + IDX_W'(1);
    end
    if (cmd.emit_load) begin
      k                         <= k + IDX_W'(1);
      elapsed                   <= tat[ELAPSED_W-1:0];
      wacc                      <= wacc_next;
      tacc                      <= tacc_next;
      out_word.job_id           <= rd.id;
      out_word.job_burst        <= rd.burst;
      out_word.job_prio         <= rd.prio;
      out_word.wait_time        <= elapsed[WAIT_W-1:0];
      out_word.turnaround       <= tat[WAIT_W-1:0];
      out_word.total_wait       <= wacc_next;
      out_word.total_turnaround <= tacc_next;
      out_word.dropped_jobs     <= ovf;
      out_word.final_slot       <= status.final_k;
    end
  end

  a_scan_order: assert property (@(posedge clk) disable iff (rst)
    cmd.scan |-> (j > i))
    else $error("sort scan index not past current position");

  a_close_nonempty: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && cmd.close) |=> (count != '0))
    else $error("batch closed with no stored job");

  a_batch_clear: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_load && status.final_k) |=> ((count == '0) && !ovf))
    else $error("batch state not cleared after final slot");

endmodule
